/* rtl/core/dbgatp_pkg.sv */
// dbgatp_pkg: shared types and constants of the debug argument token parser
// no dependencies; imported by debug_argument_token_parser_unit and its testbench
`timescale 1ns / 1ps

package dbgatp_pkg;

   // register file geometry
   localparam int unsigned REG_COUNT = 16;
   localparam int unsigned REG_IDX_W = $clog2(REG_COUNT);
   localparam int unsigned DATA_W    = 32;

   // request kinds carried on req_type
   typedef logic [1:0] req_kind_type;
   localparam req_kind_type REQ_CHAR  = 2'd0;
   localparam req_kind_type REQ_EOL   = 2'd1;
   localparam req_kind_type REQ_WRITE = 2'd2;

   // token parse phases
   typedef enum logic [3:0] {
      PH_ROOT,
      PH_REG,
      PH_REG2,
      PH_LR,
      PH_PC,
      PH_SP,
      PH_DEC,
      PH_HEX,
      PH_PREFIX,
      PH_SUFFIX
   } phase_type;

   // named register slots
   localparam logic [REG_IDX_W-1:0] IDX_SP = REG_IDX_W'(13);
   localparam logic [REG_IDX_W-1:0] IDX_LR = REG_IDX_W'(14);
   localparam logic [REG_IDX_W-1:0] IDX_PC = REG_IDX_W'(15);
   localparam logic [REG_IDX_W-1:0] IDX_HI_BASE = REG_IDX_W'(10);

   // characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_1      = 8'h31;
   localparam logic [7:0] CH_5      = 8'h35;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UA     = 8'h41;
   localparam logic [7:0] CH_UF     = 8'h46;
   localparam logic [7:0] CH_UX     = 8'h58;
   localparam logic [7:0] CH_LA     = 8'h61;
   localparam logic [7:0] CH_LC     = 8'h63;
   localparam logic [7:0] CH_LF     = 8'h66;
   localparam logic [7:0] CH_LL     = 8'h6c;
   localparam logic [7:0] CH_LP     = 8'h70;
   localparam logic [7:0] CH_LR     = 8'h72;
   localparam logic [7:0] CH_LS     = 8'h73;
   localparam logic [7:0] CH_LX     = 8'h78;

   // letter digit offset: low nibble of 'a'/'A' is 1, digit value is nibble + 9
   localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

   // one result word
   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              is_error;
   } rsp_word_type;

endpackage

/* rtl/core/debug_argument_token_parser_unit.sv */
// debug_argument_token_parser_unit: character-serial debugger argument parser
// with a 16-entry register file in a synchronous memory; depends on dbgatp_pkg
`timescale 1ns / 1ps

// usage
//  - req channel: one word per item; req_type selects a character (req_char_code),
//    end of line, or a register file write (req_reg_index, req_reg_value)
//  - rsp channel: one word per finished token (rsp_value) or per first bad
//    character of a line (rsp_is_error set, rsp_value zero)
//  - one item accepted per cycle while req_ready is high; the per-character accumulator
//    update and the register file read of the naming character happen as the item is taken
//  - a result is registered into the output queue as the item that caused it is accepted
//  - register names read the memory at the naming character; the registered read
//    data then stands in for the accumulator until the token ends, so a space
//    right after the name is served with no bubble
//  - results go through a two-word output queue; req_ready drops only when both
//    words wait, so an item is still taken while one result is stalled
//  - reset (synchronous, active high) returns the line state to the start of a
//    token, empties the queue and marks every register as zero through a row of
//    valid bits; the memory itself is not swept
module debug_argument_token_parser_unit
   import dbgatp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  logic [7:0]           req_char_code,
   input  logic [REG_IDX_W-1:0] req_reg_index,
   input  logic [DATA_W-1:0]    req_reg_value,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_value,
   output logic                 rsp_is_error
);

   // line state
   phase_type            phase_ff, phase_in;
   logic [DATA_W-1:0]    acc_ff, acc_in;
   logic                 acc_sel_ff, acc_sel_in;   // accumulator is the memory read data
   logic                 started_ff, started_in;
   logic                 halted_ff, halted_in;

   // register file
   logic [DATA_W-1:0]    regfile_mem [REG_COUNT];
   logic [REG_COUNT-1:0] rf_valid_ff;
   logic [DATA_W-1:0]    rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_en;
   logic [REG_IDX_W-1:0] rd_addr;
   logic                 wr_en;

   // output queue
   rsp_word_type         q0_ff, q0_in, q1_ff, q1_in;
   logic                 q0_valid_ff, q0_valid_in, q1_valid_ff, q1_valid_in;
   logic                 push, pop;
   rsp_word_type         push_word;

   // decode helpers
   logic                 in_fire;
   logic [7:0]           cc;
   logic                 is_dig, is_lhex, is_uhex;
   logic [3:0]           hex_val;
   logic [DATA_W-1:0]    acc_eff;
   logic                 bad;

   assign in_fire = req_valid && req_ready;
   assign req_ready = !q1_valid_ff;
   assign pop = q0_valid_ff && rsp_ready;
   assign wr_en = in_fire && (req_type == REQ_WRITE);

   assign cc      = req_char_code;
   assign is_dig  = (cc >= CH_0) && (cc <= CH_9);
   assign is_lhex = (cc >= CH_LA) && (cc <= CH_LF);
   assign is_uhex = (cc >= CH_UA) && (cc <= CH_UF);
   assign hex_val = is_dig ? cc[3:0] : (cc[3:0] + HEX_LETTER_OFS);

   // never-written registers read as zero
   assign acc_eff = acc_sel_ff ? (rd_valid_ff ? rd_data_ff : '0) : acc_ff;

   // next line state and result
   always_comb begin
      phase_in   = phase_ff;
      acc_in     = acc_ff;
      acc_sel_in = acc_sel_ff;
      started_in = started_ff;
      halted_in  = halted_ff;
      rd_en      = 1'b0;
      rd_addr    = '0;
      push       = 1'b0;
      push_word  = '0;
      bad        = 1'b0;
      if (in_fire) begin
         unique case (req_type)
            REQ_EOL: begin
               push_word.value = acc_eff;
               push = !halted_ff && started_ff;
               phase_in   = PH_ROOT;
               acc_in     = '0;
               acc_sel_in = 1'b0;
               started_in = 1'b0;
               halted_in  = 1'b0;
            end
            REQ_CHAR: begin
               if (!halted_ff) begin
                  if ((cc == CH_SPACE) || (cc == CH_NUL)) begin
                     // token separator, or end of text
                     push = 1'b1;
                     push_word.value = acc_eff;
                     phase_in   = PH_ROOT;
                     acc_in     = '0;
                     acc_sel_in = 1'b0;
                     started_in = 1'b0;
                     if (cc == CH_NUL) begin
                        halted_in = 1'b1;
                     end
                  end else begin
                     started_in = 1'b1;
                     unique case (phase_ff)
                        PH_ROOT: begin
                           priority if (cc == CH_LR) begin
                              phase_in = PH_REG;
                           end else if (cc == CH_LP) begin
                              phase_in = PH_PC;
                           end else if (cc == CH_LS) begin
                              phase_in = PH_SP;
                           end else if (cc == CH_LL) begin
                              phase_in = PH_LR;
                           end else if (cc == CH_0) begin
                              phase_in = PH_PREFIX;
                           end else if (cc == CH_DOLLAR) begin
                              acc_in     = '0;
                              acc_sel_in = 1'b0;
                              phase_in   = PH_HEX;
                           end else if (is_dig) begin
                              acc_in     = DATA_W'(cc[3:0]);
                              acc_sel_in = 1'b0;
                              phase_in   = PH_DEC;
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_LR, PH_PC, PH_SP: begin
                           if (((phase_ff == PH_LR) && (cc == CH_LR)) ||
                               ((phase_ff == PH_PC) && (cc == CH_LC)) ||
                               ((phase_ff == PH_SP) && (cc == CH_LP))) begin
                              rd_en      = 1'b1;
                              rd_addr    = (phase_ff == PH_LR) ? IDX_LR :
                                           (phase_ff == PH_PC) ? IDX_PC : IDX_SP;
                              acc_sel_in = 1'b1;
                              phase_in   = PH_SUFFIX;
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_REG: begin
                           if (is_dig) begin
                              rd_en      = 1'b1;
                              rd_addr    = REG_IDX_W'(cc[3:0]);
                              acc_sel_in = 1'b1;
                              phase_in   = (cc == CH_1) ? PH_REG2 : PH_SUFFIX;
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_REG2: begin
                           if ((cc >= CH_0) && (cc <= CH_5)) begin
                              rd_en      = 1'b1;
                              rd_addr    = IDX_HI_BASE + REG_IDX_W'(cc[3:0]);
                              acc_sel_in = 1'b1;
                              phase_in   = PH_SUFFIX;
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_DEC: begin
                           if (is_dig) begin
                              // times ten as two shifts
                              acc_in = (acc_ff << 3) + (acc_ff << 1) + DATA_W'(cc[3:0]);
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_HEX: begin
                           if (is_dig || is_lhex || is_uhex) begin
                              acc_in = {acc_ff[DATA_W-5:0], hex_val};
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_PREFIX: begin
                           if ((cc == CH_LX) || (cc == CH_UX)) begin
                              acc_in     = '0;
                              acc_sel_in = 1'b0;
                              phase_in   = PH_HEX;
                           end else begin
                              bad = 1'b1;
                           end
                        end
                        PH_SUFFIX: begin
                           bad = 1'b1;
                        end
                        default: begin
                           bad = 1'b1;
                        end
                     endcase
                     if (bad) begin
                        // first bad character: report once, ignore the rest of the line
                        push = 1'b1;
                        push_word.value    = '0;
                        push_word.is_error = 1'b1;
                        phase_in   = PH_ROOT;
                        acc_in     = '0;
                        acc_sel_in = 1'b0;
                        started_in = 1'b0;
                        halted_in  = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // register writes touch only the memory and its written marks; unused kind is dropped
            end
         endcase
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_ROOT;
         acc_ff     <= '0;
         acc_sel_ff <= 1'b0;
         started_ff <= 1'b0;
         halted_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         acc_ff     <= acc_in;
         acc_sel_ff <= acc_sel_in;
         started_ff <= started_in;
         halted_ff  <= halted_in;
      end
   end

   // register file memory, one write and one registered read per cycle;
   // a write and a read never share a cycle since each comes from its own item
   always_ff @(posedge clock) begin
      if (wr_en) begin
         regfile_mem[req_reg_index] <= req_reg_value;
      end
      if (rd_en) begin
         rd_data_ff <= regfile_mem[rd_addr];
      end
   end

   // per-entry written marks and the mark of the last read
   always_ff @(posedge clock) begin
      if (reset) begin
         rf_valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            rf_valid_ff[req_reg_index] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= rf_valid_ff[rd_addr];
         end
      end
   end

   // two-word output queue, q0 is the head
   always_comb begin
      q0_in       = q0_ff;
      q1_in       = q1_ff;
      q0_valid_in = q0_valid_ff;
      q1_valid_in = q1_valid_ff;
      if (pop) begin
         if (q1_valid_ff) begin
            q0_in       = q1_ff;
            q1_in       = push_word;
            q1_valid_in = push;
         end else begin
            q0_in       = push_word;
            q0_valid_in = push;
         end
      end else if (push) begin
         if (q0_valid_ff) begin
            q1_in       = push_word;
            q1_valid_in = 1'b1;
         end else begin
            q0_in       = push_word;
            q0_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q0_valid_ff <= 1'b0;
         q1_valid_ff <= 1'b0;
      end else begin
         q0_valid_ff <= q0_valid_in;
         q1_valid_ff <= q1_valid_in;
      end
   end

   assign rsp_valid    = q0_valid_ff;
   assign rsp_value    = q0_ff.value;
   assign rsp_is_error = q0_ff.is_error;

`ifndef SYNTHESIS
   // the second queue word is only ever filled behind the head
   a_queue_order: assert property (@(posedge clock) disable iff (reset)
      q1_valid_ff |-> q0_valid_ff)
      else $error("output queue second word valid with empty head");

   // error results never carry a value
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_error) |-> (rsp_value == '0))
      else $error("error result with nonzero value");

   // end of line always reopens the line at the start of a token
   a_eol_clears: assert property (@(posedge clock) disable iff (reset)
      (in_fire && (req_type == REQ_EOL)) |=>
         (!halted_ff && !started_ff && !acc_sel_ff && (phase_ff == PH_ROOT)))
      else $error("line state not cleared after end of line");

   // memory data stands in for the accumulator only after a register name
   a_acc_sel_phase: assert property (@(posedge clock) disable iff (reset)
      acc_sel_ff |-> ((phase_ff == PH_SUFFIX) || (phase_ff == PH_REG2)))
      else $error("register read data selected outside a register token");

   // a halted line takes no register reads
   a_halt_no_read: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !rd_en)
      else $error("register read while line halted");
`endif

endmodule

/* test/debug_argument_token_parser_unit_tb.sv */
// debug_argument_token_parser_unit_tb: self-checking bench for the token parser,
// directed rows then random argument lines and noise through a shadow parser and register file
// depends on dbgatp_pkg and debug_argument_token_parser_unit
`timescale 1ns / 1ps

module debug_argument_token_parser_unit_tb;
   import dbgatp_pkg::*;

   localparam int           HALF_PERIOD  = 6;
   localparam int           RANDOM_WORDS = 1300;
   localparam int           HOLD_CYCLES  = 80;
   localparam int           DRAIN_LIMIT  = 5000;
   // request code the block leaves unused
   localparam req_kind_type REQ_SPARE    = 2'd3;

   // how a stimulus row is checked
   typedef enum logic [1:0] {
      CHK_MODEL,  // expectation from the shadow parser
      CHK_NONE,   // typed in: no result
      CHK_WORD    // typed in: exp_val / exp_err
   } chk_kind_type;

   typedef struct packed {
      req_kind_type         kind;
      logic [7:0]           ch;
      logic [REG_IDX_W-1:0] idx;
      logic [DATA_W-1:0]    wval;
      chk_kind_type         chk;
      logic [DATA_W-1:0]    exp_val;
      logic                 exp_err;
   } stim_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [1:0]           req_type;
   logic [7:0]           req_char_code;
   logic [REG_IDX_W-1:0] req_reg_index;
   logic [DATA_W-1:0]    req_reg_value;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [DATA_W-1:0]    rsp_value;
   logic                 rsp_is_error;

   // shadow copy of the parser state
   phase_type            tok_phase;
   logic [DATA_W-1:0]    tok_acc;
   bit                   line_stop;
   bit                   tok_open;
   logic [DATA_W-1:0]    shadow_regs [REG_COUNT];

   // result words still owed by the block, oldest first
   rsp_word_type         pending_words [$];
   stim_row_type         dir_rows [$];

   int                   fails = 0;
   int                   words_sent = 0;
   int                   words_skipped = 0;
   int                   words_checked = 0;
   int                   errors_seen = 0;
   int                   send_idle_pct = 0;
   int                   stall_pct = 0;
   int                   hold_left = 0;

   debug_argument_token_parser_unit i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_reg_index (req_reg_index),
      .req_reg_value (req_reg_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value     (rsp_value),
      .rsp_is_error  (rsp_is_error)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // hard stop in case the handshake locks up
   initial begin
      #2_400_000;
      $display("** debug_argument_token_parser_unit: FAILED **");
      $finish;
   end

   function automatic void note_failure(input string msg);
      fails++;
      if (fails <= 10) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------------
   // shadow parser
   // ---------------------------------------------------------------------

   function automatic void drop_token();
      tok_phase = PH_ROOT;
      tok_acc   = '0;
      tok_open  = 1'b0;
   endfunction

   // hex digit value, bit 4 set when the character is no hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
      if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA) + 5'd10;
      if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA) + 5'd10;
      return 5'd16;
   endfunction

   // one character into the current token; 0 on a bad character
   function automatic bit advance_token(input logic [7:0] c);
      bit         dig;
      logic [4:0] h;
      dig = (c >= CH_0 && c <= CH_9);
      case (tok_phase)
         PH_ROOT: begin
            if (c == CH_LR) tok_phase = PH_REG;
            else if (c == CH_LP) tok_phase = PH_PC;
            else if (c == CH_LS) tok_phase = PH_SP;
            else if (c == CH_LL) tok_phase = PH_LR;
            else if (c == CH_0) tok_phase = PH_PREFIX;
            else if (c == CH_DOLLAR) begin
               tok_acc   = '0;
               tok_phase = PH_HEX;
            end else if (dig) begin
               tok_acc   = {24'd0, c - CH_0};
               tok_phase = PH_DEC;
            end else return 1'b0;
            return 1'b1;
         end
         PH_LR: begin
            if (c != CH_LR) return 1'b0;
            tok_acc   = shadow_regs[IDX_LR];
            tok_phase = PH_SUFFIX;
            return 1'b1;
         end
         PH_PC: begin
            if (c != CH_LC) return 1'b0;
            tok_acc   = shadow_regs[IDX_PC];
            tok_phase = PH_SUFFIX;
            return 1'b1;
         end
         PH_SP: begin
            if (c != CH_LP) return 1'b0;
            tok_acc   = shadow_regs[IDX_SP];
            tok_phase = PH_SUFFIX;
            return 1'b1;
         end
         PH_REG: begin
            if (!dig) return 1'b0;
            tok_acc   = shadow_regs[REG_IDX_W'(c - CH_0)];
            // r1 may still grow into r10..r15
            tok_phase = (c == CH_1) ? PH_REG2 : PH_SUFFIX;
            return 1'b1;
         end
         PH_REG2: begin
            if (c < CH_0 || c > CH_5) return 1'b0;
            tok_acc   = shadow_regs[REG_IDX_W'(c - CH_0) + IDX_HI_BASE];
            tok_phase = PH_SUFFIX;
            return 1'b1;
         end
         PH_DEC: begin
            if (!dig) return 1'b0;
            tok_acc = tok_acc * 32'd10 + {24'd0, c - CH_0};
            return 1'b1;
         end
         PH_HEX: begin
            h = hex_digit(c);
            if (h[4]) return 1'b0;
            tok_acc = {tok_acc[DATA_W-5:0], h[3:0]};
            return 1'b1;
         end
         PH_PREFIX: begin
            if (c != CH_LX && c != CH_UX) return 1'b0;
            tok_acc   = '0;
            tok_phase = PH_HEX;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // whole request word: state update and the result it owes, if any
   task automatic parse_word(input stim_row_type w, output bit has_res,
                             output rsp_word_type res, output bit skipped);
      has_res = 1'b0;
      skipped = 1'b0;
      res     = '0;
      if (w.kind == REQ_WRITE) begin
         shadow_regs[w.idx] = w.wval;
      end else if (w.kind == REQ_EOL) begin
         // only a token that holds a character is flushed
         if (!line_stop && tok_open) begin
            has_res   = 1'b1;
            res.value = tok_acc;
         end
         drop_token();
         line_stop = 1'b0;
      end else if (w.kind != REQ_CHAR || line_stop) begin
         skipped = 1'b1;
      end else if (w.ch == CH_SPACE || w.ch == CH_NUL) begin
         // separator, even an empty token gives its zero
         has_res   = 1'b1;
         res.value = tok_acc;
         drop_token();
         if (w.ch == CH_NUL) line_stop = 1'b1;
      end else begin
         tok_open = 1'b1;
         if (!advance_token(w.ch)) begin
            drop_token();
            line_stop    = 1'b1;
            has_res      = 1'b1;
            res.is_error = 1'b1;
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   function automatic stim_row_type row(input req_kind_type k, input logic [7:0] c,
                                        input logic [REG_IDX_W-1:0] i,
                                        input logic [DATA_W-1:0] v, input chk_kind_type chk,
                                        input logic [DATA_W-1:0] ev, input logic ee);
      stim_row_type r;
      r.kind    = k;
      r.ch      = c;
      r.idx     = i;
      r.wval    = v;
      r.chk     = chk;
      r.exp_val = ev;
      r.exp_err = ee;
      return r;
   endfunction

   // offer one word from a falling edge, hold it until taken, then book it
   task automatic send_word(input stim_row_type w);
      bit           has_res;
      bit           skipped;
      rsp_word_type res;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_type      = w.kind;
      req_char_code = w.ch;
      req_reg_index = w.idx;
      req_reg_value = w.wval;
      do @(posedge clock); while (!req_ready);
      parse_word(w, has_res, res, skipped);
      if (w.chk == CHK_WORD) begin
         res.value    = w.exp_val;
         res.is_error = w.exp_err;
         pending_words.push_back(res);
      end else if (w.chk == CHK_MODEL && has_res) begin
         pending_words.push_back(res);
      end
      words_sent++;
      if (skipped) words_skipped++;
      @(negedge clock);
   endtask

   // sender pauses until every owed word is back
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_words.size() != 0) @(negedge clock);
   endtask

   // character word, now and then preceded by a register file write
   task automatic send_char(input logic [7:0] c);
      if ($urandom_range(0, 99) < 6)
         send_word(row(REQ_WRITE, 8'($urandom), REG_IDX_W'($urandom), $urandom,
                       CHK_MODEL, '0, 1'b0));
      send_word(row(REQ_CHAR, c, REG_IDX_W'($urandom), $urandom, CHK_MODEL, '0, 1'b0));
   endtask

   task automatic send_eol();
      send_word(row(REQ_EOL, 8'($urandom), REG_IDX_W'($urandom), $urandom,
                    CHK_MODEL, '0, 1'b0));
   endtask

   function automatic logic [7:0] pick_hex_char();
      int r;
      r = $urandom_range(0, 21);
      if (r < 10) return CH_0 + 8'(r);
      if (r < 16) return CH_LA + 8'(r - 10);
      return CH_UA + 8'(r - 16);
   endfunction

   // r0..r15, sp, lr or pc
   task automatic send_reg_name();
      int r;
      r = $urandom_range(0, 18);
      if (r < REG_COUNT) begin
         send_char(CH_LR);
         if (r >= 10) begin
            send_char(CH_1);
            send_char(CH_0 + 8'(r - 10));
         end else begin
            send_char(CH_0 + 8'(r));
         end
      end else if (r == 16) begin
         send_char(CH_LS);
         send_char(CH_LP);
      end else if (r == 17) begin
         send_char(CH_LL);
         send_char(CH_LR);
      end else begin
         send_char(CH_LP);
         send_char(CH_LC);
      end
   endtask

   task automatic send_token();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1: begin
            // decimal, long ones wrap
            send_char(8'($urandom_range(CH_1, CH_9)));
            repeat ($urandom_range(0, 11)) send_char(8'($urandom_range(CH_0, CH_9)));
         end
         2, 3: begin
            if ($urandom_range(0, 1)) begin
               send_char(CH_DOLLAR);
            end else begin
               send_char(CH_0);
               send_char($urandom_range(0, 1) ? CH_LX : CH_UX);
            end
            repeat ($urandom_range(1, 10)) send_char(pick_hex_char());
         end
         4, 5: send_reg_name();
         6: begin
            // token cut short
            case ($urandom_range(0, 7))
               0: send_char(CH_LR);
               1: send_char(CH_LS);
               2: send_char(CH_LL);
               3: send_char(CH_LP);
               4: send_char(CH_0);
               5: begin
                  send_char(CH_0);
                  send_char(CH_LX);
               end
               6: send_char(CH_DOLLAR);
               default: begin
                  send_char(CH_LR);
                  send_char(CH_1);
               end
            endcase
         end
         7: ;  // empty token
         8: repeat ($urandom_range(1, 3)) send_char(8'($urandom));
         default: begin
            // anything after a complete register name
            send_reg_name();
            send_char(8'($urandom));
         end
      endcase
   endtask

   task automatic send_line();
      int n;
      int ending;
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         if (i > 0) send_char(CH_SPACE);
         send_token();
      end
      ending = $urandom_range(0, 19);
      if (ending >= 17) begin
         send_char(CH_NUL);
         repeat ($urandom_range(0, 3)) send_char(8'($urandom));
      end else if (ending >= 14) begin
         send_char(CH_SPACE);
      end
      send_eol();
   endtask

   // any request code, any character
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_word(row(req_kind_type'($urandom), 8'($urandom), REG_IDX_W'($urandom),
                       $urandom, CHK_MODEL, '0, 1'b0));
      send_eol();
   endtask

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------

   // ready moves at the falling edge; a long hold-off runs first when asked
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = !($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            note_failure($sformatf("unexpected word value=%h is_error=%b",
                                   rsp_value, rsp_is_error));
         end else begin
            exp_word = pending_words.pop_front();
            words_checked++;
            if (rsp_is_error) errors_seen++;
            if (rsp_value !== exp_word.value)
               note_failure($sformatf("value exp=%h got=%h", exp_word.value, rsp_value));
            if (rsp_is_error !== exp_word.is_error)
               note_failure($sformatf("is_error exp=%b got=%b",
                                      exp_word.is_error, rsp_is_error));
         end
      end
   end

   // ---------------------------------------------------------------------
   // main flow
   // ---------------------------------------------------------------------

   initial begin
      int target;
      int guard;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = REQ_CHAR;
      req_char_code = '0;
      req_reg_index = '0;
      req_reg_value = '0;
      drop_token();
      line_stop = 1'b0;
      foreach (shadow_regs[i]) shadow_regs[i] = '0;

      // directed rows: typed-in results where they are plain to see
      dir_rows.push_back(row(REQ_CHAR, CH_SPACE, '0, '0, CHK_WORD, 32'h0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_LS, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_LP, '0, '0, CHK_NONE, '0, 1'b0));
      // sp of a freshly cleared register file
      dir_rows.push_back(row(REQ_CHAR, CH_SPACE, '0, '0, CHK_WORD, 32'h0, 1'b0));
      dir_rows.push_back(row(REQ_WRITE, CH_NUL, IDX_PC, 32'hFFFF_FFFF, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_WRITE, 8'hFF, REG_IDX_W'(1), 32'h8000_0001, CHK_NONE,
                             '0, 1'b0));
      // bare r1 at end of line reads register 1
      dir_rows.push_back(row(REQ_CHAR, CH_LR, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_1, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_WORD, 32'h8000_0001, 1'b0));
      // pc then one more letter is an error, rest of line ignored
      dir_rows.push_back(row(REQ_CHAR, CH_LP, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_LC, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_LX, '0, '0, CHK_WORD, 32'h0, 1'b1));
      dir_rows.push_back(row(REQ_CHAR, CH_9, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_NONE, '0, 1'b0));
      // empty line
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_NONE, '0, 1'b0));
      // 0X cut short by NUL, spare request code in the middle
      dir_rows.push_back(row(REQ_CHAR, CH_0, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_UX, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_SPARE, 8'hFF, 4'hF, 32'hFFFF_FFFF, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_NUL, '0, '0, CHK_WORD, 32'h0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_5, '0, '0, CHK_NONE, '0, 1'b0));
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_NONE, '0, 1'b0));
      // mixed-case hex, then a trailing space
      dir_rows.push_back(row(REQ_CHAR, CH_DOLLAR, '0, '0, CHK_MODEL, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_LF, '0, '0, CHK_MODEL, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_UA, '0, '0, CHK_MODEL, '0, 1'b0));
      dir_rows.push_back(row(REQ_CHAR, CH_SPACE, '0, '0, CHK_MODEL, '0, 1'b0));
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_NONE, '0, 1'b0));
      // top character code is no token start
      dir_rows.push_back(row(REQ_CHAR, 8'hFF, '0, '0, CHK_WORD, 32'h0, 1'b1));
      dir_rows.push_back(row(REQ_EOL, '0, '0, '0, CHK_NONE, '0, 1'b0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) send_word(dir_rows[i]);
      wait_drained();

      // random lines and noise in four idling phases
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
               // receiver backs off while lines keep coming: queue fills, req stalls
               hold_left     = HOLD_CYCLES;
            end
            1: begin
               send_idle_pct = 64;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 64;
            end
            default: begin
               send_idle_pct = 25;
               stall_pct     = 25;
            end
         endcase
         target = words_sent + RANDOM_WORDS / 4;
         while (words_sent < target) begin
            if ($urandom_range(0, 9) == 0) send_noise();
            else send_line();
         end
         wait_drained();
      end

      // drain with a bound, then leave room for stray words
      req_valid = 1'b0;
      guard     = 0;
      while (pending_words.size() != 0 && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      if (pending_words.size() != 0)
         note_failure($sformatf("%0d words never arrived", pending_words.size()));
      repeat (10) @(negedge clock);

      $display("run covered %0d request words (%0d ignored) and checked %0d results (%0d errors)",
               words_sent, words_skipped, words_checked, errors_seen);
      $display("directed rows, random lines and noise over four idling phases, %0d failures",
               fails);
      if (fails == 0) begin
         $display("** debug_argument_token_parser_unit: PASSED **");
      end else begin
         $display("** debug_argument_token_parser_unit: FAILED **");
      end
      $finish;
   end

endmodule
